[sv/sct_pkg.sv]
// shared types and constants for the degree-input sine/cosine series pipeline
`default_nettype none

package sct_pkg;

	// default number of series terms
	localparam int TERMS_DEF = 26;

	// field widths
	localparam int ANG_W = 19;
	localparam int VAL_W = 32;
	localparam int MAG_W = 18;

	// internal widths: radians and series terms in Q.46, accumulator in Q17.46
	localparam int FRAC_W = 46;
	localparam int X_W    = 50;
	localparam int T_W    = 64;
	localparam int ACC_W  = 64;

	// cell index bound: cell numbers stay below 2^NUM_W
	localparam int NUM_W  = 6;
	localparam int QUO_SH = X_W + NUM_W;

	// operand split points of the wide multipliers
	localparam int DIV_LW = 29;
	localparam int MUL_LW = 32;

	// kind codes
	localparam logic KIND_SIN = 1'b0;
	localparam logic KIND_COS = 1'b1;

	// angle clamp, plus or minus 720 degrees in Q10.8
	localparam logic signed [ANG_W-1:0] ANG_MAX = ANG_W'(184320);
	localparam logic signed [ANG_W-1:0] ANG_MIN = ANG_W'(-184320);

	// degrees to radians: x = (mag * pi_q44 + 5760) / 11520, with 11520 = 45 * 256
	localparam int PI_W     = 46;
	localparam logic [PI_W-1:0] PI_Q44 = 46'h3243F6A8885A;
	localparam int RAD_DEN  = 11520;
	localparam int RQ_W     = 33;
	localparam int RR_W     = 14;
	localparam logic [RQ_W-1:0] RAD_Q = RQ_W'(PI_Q44 / PI_W'(RAD_DEN));
	localparam logic [RR_W-1:0] RAD_R = RR_W'(PI_Q44 % PI_W'(RAD_DEN));
	localparam int LO_W     = 32;
	localparam logic [LO_W-1:0] RAD_HALF = LO_W'(5760);
	localparam int DEN_SH   = 8;
	localparam int W_W      = LO_W - DEN_SH;
	localparam logic [W_W-1:0] DEN_ODD = W_W'(45);
	localparam int RCP_SH   = 29;
	localparam logic [W_W-1:0] RCP_ODD = W_W'((64'd1 << RCP_SH) / 64'd45);
	localparam int Q0_W     = 2 * W_W - RCP_SH;

	// term constants
	localparam logic [T_W-1:0] ONE_Q46   = T_W'(64'd1 << FRAC_W);
	localparam logic [T_W-1:0] HALF_Q46  = T_W'(64'd1 << (FRAC_W - 1));
	localparam logic [T_W-1:0] TERM_SAT  = T_W'((64'd1 << 62) - 64'd1);

	// output rounding: offset by 2^62 plus half an output lsb, then drop 16 bits
	localparam int OUT_SH = 16;
	localparam int RU_W   = ACC_W - OUT_SH;
	localparam logic [ACC_W-1:0] RND_OFS = (64'd1 << 62) + (64'd1 << 15);
	localparam logic [RU_W-1:0]  RU_HI   = RU_W'((64'd1 << 46) + (64'd1 << 30));
	localparam logic [RU_W-1:0]  RU_LO   = RU_W'((64'd1 << 46) - (64'd1 << 30));
	localparam logic signed [VAL_W-1:0] VAL_ONE  = 32'sh4000_0000;
	localparam logic signed [VAL_W-1:0] VAL_MONE = 32'shC000_0000;

	// control that travels with each word
	typedef struct packed {
		logic valid;
		logic kind;
		logic neg;
	} sct_ctl_t;

endpackage

`default_nettype wire

[sv/sct_wmul.sv]
// three-stage wide multiplier built from four partial products
`default_nettype none

module sct_wmul #(
	parameter int AW = sct_pkg::T_W,
	parameter int BW = sct_pkg::X_W,
	parameter int LW = sct_pkg::MUL_LW
) (
	input  logic               clk,
	input  logic               en,
	input  logic [AW-1:0]      a,
	input  logic [BW-1:0]      b,
	output logic [AW+BW-1:0]   prod
);
	import sct_pkg::*;

	localparam int AHW = AW - LW;
	localparam int BHW = BW - LW;
	localparam int PW  = AW + BW;
	localparam int P00W = 2 * LW;
	localparam int P01W = LW + BHW;
	localparam int P10W = AHW + LW;
	localparam int P11W = AHW + BHW;
	localparam int MW  = ((AW > BW) ? AW : BW) + 1;

	logic [P00W-1:0] pp00_s1, pp00_s2;
	logic [P01W-1:0] pp01_s1;
	logic [P10W-1:0] pp10_s1;
	logic [P11W-1:0] pp11_s1, pp11_s2;
	logic [MW-1:0]   mid_s2;
	logic [PW-1:0]   prod_s3;

	// partial products
	always_ff @(posedge clk) begin
		if (en) begin
			pp00_s1 <= P00W'(a[LW-1:0]) * P00W'(b[LW-1:0]);
			pp01_s1 <= P01W'(a[LW-1:0]) * P01W'(b[BW-1:LW]);
			pp10_s1 <= P10W'(a[AW-1:LW]) * P10W'(b[LW-1:0]);
			pp11_s1 <= P11W'(a[AW-1:LW]) * P11W'(b[BW-1:LW]);
		end
	end

	// cross terms share one weight
	always_ff @(posedge clk) begin
		if (en) begin
			pp00_s2 <= pp00_s1;
			pp11_s2 <= pp11_s1;
			mid_s2  <= MW'(pp01_s1) + MW'(pp10_s1);
		end
	end

	// final sum
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= PW'(pp00_s2) + (PW'(mid_s2) << LW) + (PW'(pp11_s2) << P00W);
		end
	end

	assign prod = prod_s3;

endmodule

`default_nettype wire

[sv/sct_front.sv]
// angle clamp and degree to radian conversion ahead of the term chain
`default_nettype none

module sct_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  logic                                in_valid,
	input  logic                                kind,
	input  logic signed [sct_pkg::ANG_W-1:0]    angle_deg,
	output logic [sct_pkg::X_W-1:0]             x_out,
	output sct_pkg::sct_ctl_t                   ctl_out
);
	import sct_pkg::*;

	localparam int HI_W = MAG_W + RQ_W;

	logic signed [ANG_W-1:0] ang_c;
	logic [ANG_W-1:0]        mag_w;
	logic [HI_W-1:0]         hi_p;
	logic [LO_W-1:0]         lo_p;
	logic [W_W-1:0]          w_p;
	logic [Q0_W-1:0]         q0_p;
	logic [W_W-1:0]          rem_p;
	logic                    corr;

	logic [MAG_W-1:0]        mag_s1;
	logic [X_W-1:0]          hi_s2, hi_s3, hi_s4;
	logic [LO_W-1:0]         lo_s2;
	logic [W_W-1:0]          w_s3, w_s4;
	logic [2*W_W-1:0]        wm_s3;
	logic [Q0_W-1:0]         q0_s4;
	logic [W_W-1:0]          qm_s4;
	logic [X_W-1:0]          x_s5;
	sct_ctl_t                ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	sct_ctl_t                ctl_s6, ctl_s7, ctl_s8, ctl_s9;

	// clamp and magnitude
	always_comb begin
		if (angle_deg > ANG_MAX) begin
			ang_c = ANG_MAX;
		end else if (angle_deg < ANG_MIN) begin
			ang_c = ANG_MIN;
		end else begin
			ang_c = angle_deg;
		end
		mag_w = ang_c[ANG_W-1] ? ANG_W'(-ang_c) : ANG_W'(ang_c);
	end

	// integer part of pi/180 scaling and the remainder term
	assign hi_p = HI_W'(mag_s1) * HI_W'(RAD_Q);
	assign lo_p = LO_W'(mag_s1) * LO_W'(RAD_R) + RAD_HALF;

	// remainder divided by 11520: drop 8 bits, then reciprocal of 45
	assign w_p  = lo_s2[LO_W-1:DEN_SH];
	assign q0_p = wm_s3[2*W_W-1:RCP_SH];
	assign rem_p = w_s4 - qm_s4;
	assign corr  = (rem_p >= DEN_ODD);

	// control, with four extra stages so x leads the term by the divider depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			ctl_s8 <= '0;
			ctl_s9 <= '0;
		end else if (adv) begin
			ctl_s1 <= '{valid: in_valid, kind: kind, neg: ang_c[ANG_W-1]};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
			ctl_s8 <= ctl_s7;
			ctl_s9 <= ctl_s8;
		end
	end

	// radian datapath
	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1 <= mag_w[MAG_W-1:0];
			hi_s2  <= hi_p[X_W-1:0];
			lo_s2  <= lo_p;
			hi_s3  <= hi_s2;
			w_s3   <= w_p;
			wm_s3  <= (2*W_W)'(w_p) * (2*W_W)'(RCP_ODD);
			hi_s4  <= hi_s3;
			w_s4   <= w_s3;
			q0_s4  <= q0_p;
			qm_s4  <= W_W'(W_W'(q0_p) * DEN_ODD);
			x_s5   <= hi_s4 + X_W'(q0_s4) + X_W'(corr);
		end
	end

	assign x_out   = x_s5;
	assign ctl_out = ctl_s9;

endmodule

`default_nettype wire

[sv/sct_cell.sv]
// one series cell: divides x by its term number and updates term and sum
`default_nettype none

module sct_cell #(
	parameter int NUM = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic [sct_pkg::X_W-1:0]       x_in,
	input  sct_pkg::sct_ctl_t             ctl_in,
	input  logic [sct_pkg::T_W-1:0]       t_in,
	input  logic [sct_pkg::ACC_W-1:0]     acc_in,
	output logic [sct_pkg::X_W-1:0]       x_out,
	output sct_pkg::sct_ctl_t             ctl_out,
	output logic [sct_pkg::T_W-1:0]       t_out,
	output logic [sct_pkg::ACC_W-1:0]     acc_out
);
	import sct_pkg::*;

	localparam int HALF_N = NUM / 2;
	localparam int RCP_W  = QUO_SH + 1;
	localparam logic [RCP_W-1:0] RECIP =
		RCP_W'(((64'd1 << QUO_SH) + 64'(NUM) - 64'd1) / 64'(NUM));
	localparam logic N_ODD = ((NUM % 2) == 1);
	localparam logic N_SUB = (((NUM / 2) % 2) == 1);
	localparam int DPW = X_W + RCP_W;
	localparam int TPW = T_W + X_W;

	logic [X_W-1:0]   xq_s1;
	logic [DPW-1:0]   dprod;
	logic [X_W-1:0]   step;
	logic [TPW-1:0]   tprod;
	logic [TPW:0]     rp;
	logic             sat;
	logic [T_W-1:0]   t_rnd;

	logic [X_W-1:0]   x_s1, x_s2, x_s3, x_s4, x_s5;
	logic [ACC_W-1:0] acc_s1, acc_s2, acc_s3, acc_s4, acc_s5;
	logic [T_W-1:0]   t_s4, t_s5;
	sct_ctl_t         ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;

	// rounded x / NUM for the next term; ready when this word's term arrives
	sct_wmul #(
		.AW (X_W),
		.BW (RCP_W),
		.LW (DIV_LW)
	) u_div (
		.clk  (clk),
		.en   (adv),
		.a    (xq_s1),
		.b    (RECIP),
		.prod (dprod)
	);

	assign step = dprod[QUO_SH +: X_W];

	// previous term times x / NUM
	sct_wmul #(
		.AW (T_W),
		.BW (X_W),
		.LW (MUL_LW)
	) u_mul (
		.clk  (clk),
		.en   (adv),
		.a    (t_in),
		.b    (step),
		.prod (tprod)
	);

	// round to Q.46 and saturate
	assign rp    = {1'b0, tprod} + (TPW+1)'(HALF_Q46);
	assign sat   = |rp[TPW:FRAC_W+T_W];
	assign t_rnd = sat ? TERM_SAT : rp[FRAC_W +: T_W];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	// x delay, term and accumulator
	always_ff @(posedge clk) begin
		if (adv) begin
			xq_s1  <= x_in + X_W'(HALF_N);
			x_s1   <= x_in;
			x_s2   <= x_s1;
			x_s3   <= x_s2;
			x_s4   <= x_s3;
			x_s5   <= x_s4;
			acc_s1 <= acc_in;
			acc_s2 <= acc_s1;
			acc_s3 <= acc_s2;
			acc_s4 <= acc_s3;
			t_s4   <= t_rnd;
			t_s5   <= t_s4;
			if (ctl_s4.kind != N_ODD) begin
				acc_s5 <= N_SUB ? (acc_s4 - t_s4) : (acc_s4 + t_s4);
			end else begin
				acc_s5 <= acc_s4;
			end
		end
	end

	assign x_out   = x_s5;
	assign ctl_out = ctl_s5;
	assign t_out   = t_s5;
	assign acc_out = acc_s5;

endmodule

`default_nettype wire

[sv/sine_cosine_taylor_degrees.sv]
// top level: sine or cosine of a Q10.8 degree angle by a pipelined Maclaurin series
// throughput: one word per cycle while the pipeline is not held; each of the 2 * TERMS - 1 cells adds five stages
// the whole pipeline holds only while its last stage is full and the output word waits
// reset clears the valid bits of every stage and of the output; data registers are not reset
`default_nettype none

module sine_cosine_taylor_degrees #(
	parameter int TERMS = sct_pkg::TERMS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              kind,
	input  logic signed [sct_pkg::ANG_W-1:0]  angle_deg,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [sct_pkg::VAL_W-1:0]  value
);
	import sct_pkg::*;

	localparam int CELLS = 2 * TERMS - 1;

	logic                     adv;
	logic [X_W-1:0]           x_c   [CELLS];
	logic [T_W-1:0]           t_c   [CELLS];
	sct_ctl_t                 ctl_c [CELLS+1];
	logic [ACC_W-1:0]         acc_c [CELLS+1];
	logic [ACC_W-1:0]         ofs;
	logic [RU_W-1:0]          fin_s1;
	sct_ctl_t                 fctl_s1;
	logic signed [VAL_W-1:0]  r_sat;
	logic signed [VAL_W-1:0]  r_out;
	logic                     out_valid_q;
	logic signed [VAL_W-1:0]  value_q;

	// global advance: hold only when the last stage and the output word are both full
	assign adv      = !(fctl_s1.valid && out_valid_q && out_stall);
	assign in_stall = !adv;

	// angle clamp and radians
	sct_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (in_valid),
		.kind      (kind),
		.angle_deg (angle_deg),
		.x_out     (x_c[0]),
		.ctl_out   (ctl_c[0])
	);

	// first term is one; cosine starts its sum at one
	assign t_c[0]   = ONE_Q46;
	assign acc_c[0] = (ctl_c[0].kind == KIND_COS) ? ONE_Q46 : '0;

	// chain of term cells
	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		if (i < CELLS - 1) begin : g_mid
			sct_cell #(
				.NUM (i + 1)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.adv     (adv),
				.x_in    (x_c[i]),
				.ctl_in  (ctl_c[i]),
				.t_in    (t_c[i]),
				.acc_in  (acc_c[i]),
				.x_out   (x_c[i + 1]),
				.ctl_out (ctl_c[i + 1]),
				.t_out   (t_c[i + 1]),
				.acc_out (acc_c[i + 1])
			);
		end else begin : g_last
			sct_cell #(
				.NUM (i + 1)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.adv     (adv),
				.x_in    (x_c[i]),
				.ctl_in  (ctl_c[i]),
				.t_in    (t_c[i]),
				.acc_in  (acc_c[i]),
				.x_out   (),
				.ctl_out (ctl_c[i + 1]),
				.t_out   (),
				.acc_out (acc_c[i + 1])
			);
		end
	end

	// offset and round the sum down to Q1.30 plus the 2^46 bias
	assign ofs = acc_c[CELLS] + RND_OFS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fctl_s1 <= '0;
		end else if (adv) begin
			fctl_s1 <= ctl_c[CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fin_s1 <= ofs[ACC_W-1:OUT_SH];
		end
	end

	// saturate to plus or minus one and restore the sign for sine
	always_comb begin
		if (fin_s1 > RU_HI) begin
			r_sat = VAL_ONE;
		end else if (fin_s1 < RU_LO) begin
			r_sat = VAL_MONE;
		end else begin
			r_sat = $signed(fin_s1[VAL_W-1:0]);
		end
		if (fctl_s1.neg && (fctl_s1.kind == KIND_SIN)) begin
			r_out = -r_sat;
		end else begin
			r_out = r_sat;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && fctl_s1.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fctl_s1.valid) begin
			value_q <= r_out;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;

	// a shown result never leaves the saturation range
	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((value <= VAL_ONE) && (value >= VAL_MONE)))
		else $error("result outside plus or minus one");

	// the input is held back only by a waiting output word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output back-pressure");

	// a finished word moves into an empty output register
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(fctl_s1.valid && !out_valid_q) |=> out_valid_q)
		else $error("finished word not loaded into empty output");

endmodule

`default_nettype wire

[test/tb.sv]
// testbench for the degree-input sine/cosine series pipeline, checked word by word against a local model
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sct_pkg::*;

	localparam int NUM_TERMS    = TERMS_DEF;
	localparam int RANDOM_WORDS = 1800;
	localparam int ROW_N        = 24;
	localparam int DRAIN_CYCLES = 400;

	// directed rows: a fixed value is typed in only where it is obvious
	typedef struct {
		logic                     k;
		logic signed [ANG_W-1:0]  ang;
		logic                     fixed;
		logic signed [VAL_W-1:0]  want;
	} dir_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic                     kind;
	logic signed [ANG_W-1:0]  angle_deg;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [VAL_W-1:0]  value;

	// side info that travels with the word being offered
	logic                     word_has_fixed;
	logic signed [VAL_W-1:0]  word_fixed;

	logic signed [VAL_W-1:0]  value_due [$];
	dir_row_t                 rows [ROW_N];
	int                       fail_count;
	logic                     in_quiet;
	logic                     out_quiet;

	sine_cosine_taylor_degrees uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.angle_deg (angle_deg),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("sine_cosine_taylor_degrees: mismatch");
		$finish;
	end

	// series sum in Q17.46, rounded and saturated to Q1.30
	function automatic logic signed [VAL_W-1:0] series_value(input logic k,
			input logic signed [ANG_W-1:0] ang_in);
		logic signed [ANG_W-1:0] ang;
		logic                    neg;
		logic [63:0]             mag;
		logic [63:0]             rad;
		logic [63:0]             term;
		logic [63:0]             step;
		logic [63:0]             acc;
		logic [63:0]             ru;
		logic [127:0]            prod;
		logic signed [63:0]      r;
		int                      last;
		ang = ang_in;
		if (ang > ANG_MAX)
			ang = ANG_MAX;
		if (ang < ANG_MIN)
			ang = ANG_MIN;
		neg = ang < 0;
		mag = 64'(neg ? -ang : ang);
		// degrees to radians, rounded to nearest in Q.46
		rad = (mag * 64'h3243_F6A8_885A + 64'd5760) / 64'd11520;
		term = 64'd1 << 46;
		acc = (k == KIND_COS) ? term : 64'd0;
		last = (k == KIND_COS) ? 2 * NUM_TERMS - 2 : 2 * NUM_TERMS - 1;
		for (int n = 1; n <= last; n++) begin
			step = (rad + 64'(n / 2)) / 64'(n);
			prod = {64'd0, term} * {64'd0, step} + (128'd1 << 45);
			if (prod[127:110] != '0)
				term = (64'd1 << 62) - 64'd1;
			else
				term = prod[109:46];
			if (logic'(n % 2) != k) begin
				if (((n / 2) % 2) == 1)
					acc = acc - term;
				else
					acc = acc + term;
			end
		end
		// round away 16 bits with the offset that keeps the shift non-negative
		ru = (acc + (64'd1 << 62) + (64'd1 << 15)) >> 16;
		r = $signed(ru - (64'd1 << 46));
		if (r > (64'sd1 <<< 30))
			r = 64'sd1 <<< 30;
		if (r < -(64'sd1 <<< 30))
			r = -(64'sd1 <<< 30);
		if (neg && k == KIND_SIN)
			r = -r;
		return r[VAL_W-1:0];
	endfunction

	// offer one word after a random gap, none in the quiet stretch, and hold it until taken
	task automatic send_word(input logic k, input logic signed [ANG_W-1:0] a,
			input logic fixed, input logic signed [VAL_W-1:0] want);
		int gap;
		gap = in_quiet ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		kind           <= k;
		angle_deg      <= a;
		word_has_fixed <= fixed;
		word_fixed     <= want;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// random angle: mostly in range, some raw 19-bit, some near quarter turns
	function automatic logic signed [ANG_W-1:0] pick_angle();
		int sel;
		int q;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return ANG_W'(int'($urandom_range(0, 368640)) - 184320);
		if (sel < 8)
			return ANG_W'($urandom);
		q = int'($urandom_range(0, 16)) - 8;
		return ANG_W'(q * 23040 + int'($urandom_range(0, 6)) - 3);
	endfunction

	// expected words in on input accept, checked on output accept
	always @(posedge clk) begin : check_words
		logic signed [VAL_W-1:0] want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (value_due.size() == 0) begin
					$error("value: no word pending, got %0d", value);
					fail_count++;
				end else begin
					want = value_due.pop_front();
					if (value !== want) begin
						$error("value: expected %0d, got %0d", want, value);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				value_due.push_back(word_has_fixed ? word_fixed : series_value(kind, angle_deg));
		end
	end

	// output side: random stall before each word, with a quiet stretch
	initial begin : out_side
		int n;
		int taken;
		out_stall = 1'b0;
		out_quiet = 1'b0;
		taken = 0;
		@(posedge arst_n);
		forever begin
			out_quiet = (taken >= 500 && taken < 800);
			n = out_quiet ? 0 : $urandom_range(0, 3);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			taken++;
		end
	end

	// reset, directed rows, random words, drain, verdict
	initial begin : in_side
		logic k;
		in_valid       = 1'b0;
		kind           = KIND_SIN;
		angle_deg      = '0;
		word_has_fixed = 1'b0;
		word_fixed     = '0;
		fail_count     = 0;
		in_quiet       = 1'b0;
		arst_n         = 1'b0;
		rows = '{
			'{KIND_SIN, 19'sd0,       1'b1, 32'sd0},
			'{KIND_COS, 19'sd0,       1'b1, VAL_ONE},
			'{KIND_SIN, 19'sd1,       1'b0, 32'sd0},
			'{KIND_COS, -19'sd1,      1'b0, 32'sd0},
			'{KIND_SIN, 19'sd23040,   1'b0, 32'sd0},
			'{KIND_COS, 19'sd23040,   1'b0, 32'sd0},
			'{KIND_SIN, -19'sd23040,  1'b0, 32'sd0},
			'{KIND_COS, 19'sd46080,   1'b0, 32'sd0},
			'{KIND_SIN, 19'sd46080,   1'b0, 32'sd0},
			'{KIND_SIN, 19'sd92160,   1'b0, 32'sd0},
			'{KIND_COS, 19'sd92160,   1'b0, 32'sd0},
			'{KIND_SIN, 19'sd184320,  1'b0, 32'sd0},
			'{KIND_COS, 19'sd184320,  1'b0, 32'sd0},
			'{KIND_SIN, -19'sd184320, 1'b0, 32'sd0},
			'{KIND_COS, -19'sd184320, 1'b0, 32'sd0},
			'{KIND_SIN, 19'sd184321,  1'b0, 32'sd0},
			'{KIND_COS, -19'sd184321, 1'b0, 32'sd0},
			'{KIND_SIN, 19'sd262143,  1'b0, 32'sd0},
			'{KIND_COS, -19'sd262144, 1'b0, 32'sd0},
			'{KIND_SIN, -19'sd262144, 1'b0, 32'sd0},
			'{KIND_COS, 19'sd262143,  1'b0, 32'sd0},
			'{KIND_SIN, 19'sd138240,  1'b0, 32'sd0},
			'{KIND_COS, 19'sd161280,  1'b0, 32'sd0},
			'{KIND_SIN, 19'sd11520,   1'b0, 32'sd0}
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < ROW_N; i++)
			send_word(rows[i].k, rows[i].ang, rows[i].fixed, rows[i].want);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			in_quiet = (i >= 900 && i < 1200);
			k = logic'($urandom_range(0, 1));
			send_word(k, pick_angle(), 1'b0, 32'sd0);
		end
		in_valid <= 1'b0;
		in_quiet = 1'b0;

		// drain the pipeline, then watch for stray words
		@(posedge clk);
		while (value_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("sine_cosine_taylor_degrees: match");
		else
			$display("sine_cosine_taylor_degrees: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
sv/sct_pkg.sv
sv/sct_wmul.sv
sv/sct_front.sv
sv/sct_cell.sv
sv/sine_cosine_taylor_degrees.sv
test/tb.sv
